>>> sv/mlrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_pkg: shared types and constants for the ready queue scheduler
// Command and status codes, beat structs, default sizes.
// ----------------------------------------------------------------------------
package mlrq_pkg;

  localparam int QUEUE_COUNT_DEF      = 8;
  localparam int TASK_COUNT_DEF       = 64;
  localparam int LEVELS_PER_QUEUE_DEF = 32;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_LENGTH  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NOT_RUNNABLE   = 3'd1,
    ST_ALREADY_QUEUED = 3'd2,
    ST_ALL_EMPTY      = 3'd3,
    ST_BAD_INDEX      = 3'd4,
    ST_NOT_RUNNING    = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  task_id;
    logic [7:0]  task_priority;
    logic        task_runnable;
    logic        current_is_idle;
    logic [15:0] current_slice;
    logic [3:0]  queue_index;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  found_task;
    logic        preempt_now;
    logic [15:0] new_slice;
    logic        slice_expired;
    logic [6:0]  queue_length;
  } out_beat_t;

  // Front to back: decoded command with queue number
  typedef struct packed {
    in_beat_t   beat;
    logic [3:0] qsel;
  } work_t;

endpackage

>>> sv/multilevel_ready_queue_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler_unit: multilevel priority ready queues
// Top level: config register, front intake, back executor.
// ----------------------------------------------------------------------------
// Holds QUEUE_COUNT FIFO ready queues of task ids as linked lists (queue =
// priority / LEVELS_PER_QUEUE, queue 0 highest). Commands: enqueue, dequeue
// of the best head, tick (preemption and slice), length query. One result
// beat per command beat. A dequeue that leaves its queue non-empty holds the
// executor until the new head comes back from the registered read of the
// link RAM. A two-entry queue between intake and executor lets each side
// stall independently. scheduler_running is written through
// cfg_valid/cfg_ready; write only while idle.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler_unit #(
  parameter int QUEUE_COUNT      = mlrq_pkg::QUEUE_COUNT_DEF,
  parameter int TASK_COUNT       = mlrq_pkg::TASK_COUNT_DEF,
  parameter int LEVELS_PER_QUEUE = mlrq_pkg::LEVELS_PER_QUEUE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mlrq_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mlrq_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic            scheduler_running;
  logic            wq_valid, wq_take;
  mlrq_pkg::work_t wq_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scheduler_running <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      scheduler_running <= cfg_data;
    end
  end

  mlrq_front #(.QUEUE_COUNT(QUEUE_COUNT), .LEVELS_PER_QUEUE(LEVELS_PER_QUEUE)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .wq_valid(wq_valid), .wq_take(wq_take), .wq_data(wq_data)
  );

  mlrq_back #(.QUEUE_COUNT(QUEUE_COUNT), .TASK_COUNT(TASK_COUNT)) u_back (
    .clk(clk), .rst(rst), .running(scheduler_running),
    .wq_valid(wq_valid), .wq_take(wq_take), .wq_data(wq_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

>>> sv/mlrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/mlrq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_front: command intake and classification
// Accepts input beats, maps priority to a queue, pushes into a small FIFO.
// ----------------------------------------------------------------------------
module mlrq_front #(
  parameter int QUEUE_COUNT      = mlrq_pkg::QUEUE_COUNT_DEF,
  parameter int LEVELS_PER_QUEUE = mlrq_pkg::LEVELS_PER_QUEUE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mlrq_pkg::in_beat_t in_data,
  output logic               wq_valid,
  input  logic               wq_take,
  output mlrq_pkg::work_t    wq_data
);

  mlrq_pkg::work_t fifo [2];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      fill;
  logic            push, pop;
  logic [3:0]      qsel;

  // queue = number of level thresholds reached, capped at the last queue
  always_comb begin
    qsel = 4'd0;
    for (int k = 1; k < QUEUE_COUNT; k++) begin
      if (int'(in_data.task_priority) >= k * LEVELS_PER_QUEUE) qsel = 4'(k);
    end
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign wq_valid = (fill != 2'd0);
  assign pop      = wq_valid && wq_take;
  assign wq_data  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{beat: in_data, qsel: qsel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> sv/mlrq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_back: queue state and command execution
// Heads, tails, counts in registers; link table in RAM; output register.
// ----------------------------------------------------------------------------
module mlrq_back #(
  parameter int QUEUE_COUNT = mlrq_pkg::QUEUE_COUNT_DEF,
  parameter int TASK_COUNT  = mlrq_pkg::TASK_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                running,
  input  logic                wq_valid,
  output logic                wq_take,
  input  mlrq_pkg::work_t     wq_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mlrq_pkg::out_beat_t out_data
);

  localparam int TW = $clog2(TASK_COUNT);
  localparam int QW = $clog2(QUEUE_COUNT);

  // Two phases: EXEC decides; a dequeue with a successor then waits in LINK
  // for the link RAM read before writing the new head.
  logic            link_wait;
  logic [QW-1:0]   link_q;

  logic [TW-1:0]   head  [QUEUE_COUNT];
  logic [TW-1:0]   tail  [QUEUE_COUNT];
  logic [6:0]      count [QUEUE_COUNT];
  logic [TASK_COUNT-1:0] queued;

  logic            ram_we;
  logic [TW-1:0]   ram_wa, ram_wd, ram_ra, ram_rd;

  mlrq_ram #(.WIDTH(TW), .DEPTH(TASK_COUNT)) u_link (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  mlrq_pkg::in_beat_t b;
  logic [QW-1:0]   q;
  logic [TW-1:0]   id;
  logic            id_bad;
  logic [QUEUE_COUNT-1:0] nonempty;
  logic            any_ne, any_hi, found;
  logic [QW-1:0]   best;
  logic            fire;
  mlrq_pkg::out_beat_t res;
  logic            do_enq, do_deq;

  assign b      = wq_data.beat;
  assign q      = wq_data.qsel[QW-1:0];
  assign id     = b.task_id[TW-1:0];
  assign id_bad = ({26'd0, b.task_id} >= 32'(TASK_COUNT));

  always_comb begin
    found  = 1'b0;
    best   = '0;
    any_hi = 1'b0;
    for (int i = 0; i < QUEUE_COUNT; i++) begin
      nonempty[i] = (count[i] != 7'd0);
      if (nonempty[i] && !found) begin
        found = 1'b1;
        best  = QW'(i);
      end
      if (nonempty[i] && (i < int'(wq_data.qsel))) any_hi = 1'b1;
    end
    any_ne = found;
  end

  assign wq_take = wq_valid && !link_wait && !(out_valid && out_stall);
  assign fire    = wq_take;

  always_comb begin
    res    = '0;
    do_enq = 1'b0;
    do_deq = 1'b0;
    case (mlrq_pkg::cmd_t'(b.command))
      mlrq_pkg::CMD_ENQUEUE: begin
        if (id_bad)                res.status = mlrq_pkg::ST_BAD_INDEX;
        else if (!b.task_runnable) res.status = mlrq_pkg::ST_NOT_RUNNABLE;
        else if (queued[id])       res.status = mlrq_pkg::ST_ALREADY_QUEUED;
        else                       do_enq = 1'b1;
      end
      mlrq_pkg::CMD_DEQUEUE: begin
        if (any_ne) begin
          do_deq = 1'b1;
          res.found_task = 6'(head[best]);
        end else begin
          res.status = mlrq_pkg::ST_ALL_EMPTY;
        end
      end
      mlrq_pkg::CMD_TICK: begin
        res.new_slice = b.current_slice;
        if (!running) begin
          res.status = mlrq_pkg::ST_NOT_RUNNING;
        end else begin
          res.preempt_now = b.current_is_idle ? any_ne : any_hi;
          if (!b.current_is_idle && !any_hi && b.current_slice != 16'd0)
            res.new_slice = b.current_slice - 16'd1;
          res.slice_expired = (res.new_slice == 16'd0);
        end
      end
      mlrq_pkg::CMD_LENGTH: begin
        if (32'(b.queue_index) >= 32'(QUEUE_COUNT))
          res.status = mlrq_pkg::ST_BAD_INDEX;
        else
          res.queue_length = count[b.queue_index[QW-1:0]];
      end
      default: res = '0;
    endcase
  end

  assign ram_we = fire && do_enq && nonempty[q];
  assign ram_wa = tail[q];
  assign ram_wd = id;
  assign ram_ra = head[best];

  always_ff @(posedge clk) begin
    if (fire && do_enq) begin
      if (!nonempty[q]) head[q] <= id;
      tail[q] <= id;
    end
    if (link_wait) head[link_q] <= ram_rd;
    if (fire) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_wait <= 1'b0;
      link_q    <= '0;
      out_valid <= 1'b0;
      queued    <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) count[i] <= 7'd0;
    end else begin
      link_wait <= 1'b0;
      if (fire) begin
        out_valid <= 1'b1;
        if (do_enq) begin
          count[q]   <= count[q] + 7'd1;
          queued[id] <= 1'b1;
        end
        if (do_deq) begin
          count[best]        <= count[best] - 7'd1;
          queued[head[best]] <= 1'b0;
          link_q             <= best;
          link_wait          <= (count[best] != 7'd1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/mlrq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlrq_checker: port-level checks
// Watches the top level's ports over time.
// ----------------------------------------------------------------------------
module mlrq_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mlrq_pkg::out_beat_t out_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // no result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // only valid status codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= mlrq_pkg::ST_NOT_RUNNING)
    else $error("bad status");

  // expired slice means nothing left
  a_expire: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.slice_expired |-> out_data.new_slice == 16'd0)
    else $error("expired with slice left");

  // intake stall is always defined while a beat is offered
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !$isunknown(in_stall))
    else $error("unknown intake stall");

endmodule

bind multilevel_ready_queue_scheduler_unit mlrq_checker u_mlrq_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for multilevel_ready_queue_scheduler_unit
// A directed table covers reset state, extremes and every status code. A long
// random run follows, with enqueue/dequeue traffic that fills and drains the
// queues. Both handshakes idle at several rates. Each result beat is checked
// field by field against the row's expected result or an in-bench queue model.
// ----------------------------------------------------------------------------
module tb;

  localparam int NQ        = mlrq_pkg::QUEUE_COUNT_DEF;
  localparam int NT        = mlrq_pkg::TASK_COUNT_DEF;
  localparam int LVL       = mlrq_pkg::LEVELS_PER_QUEUE_DEF;
  localparam int IDLE_LIM  = 5000;   // cycles with no beat anywhere
  localparam int DRAIN_GAP = 8;      // settle time before a register write
  localparam int PHASE_N   = 340;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic                cfg_val;
    mlrq_pkg::in_beat_t  beat;
    bit                  typed;      // expected result given in the row
    mlrq_pkg::out_beat_t result;
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mlrq_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mlrq_pkg::out_beat_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;

  // model state
  logic [5:0] head_of [NQ];
  logic [5:0] tail_of [NQ];
  int         depth_of[NQ];
  logic [5:0] link_of [NT];
  bit         on_queue[NT];
  bit         sched_on;

  mlrq_pkg::out_beat_t pending_results[$];
  row_t      rows[$];
  int        errors = 0;
  int        beats_in = 0, beats_out = 0;
  int        cmd_seen[4];
  int        send_idle = 0, recv_stall = 0;
  int        idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multilevel_ready_queue_scheduler_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic int level_of(logic [7:0] prio);
    int q;
    q = int'(prio) / LVL;
    return (q >= NQ) ? NQ - 1 : q;
  endfunction

  function automatic bit busy_above(int lim);
    for (int i = 0; i < lim; i++)
      if (depth_of[i] != 0) return 1'b1;
    return 1'b0;
  endfunction

  // Advance the ready queue model by one command beat
  function automatic mlrq_pkg::out_beat_t schedule_model(mlrq_pkg::in_beat_t b);
    mlrq_pkg::out_beat_t r;
    int q;
    r = '0;
    r.status = mlrq_pkg::ST_OK;
    case (mlrq_pkg::cmd_t'(b.command))
      mlrq_pkg::CMD_ENQUEUE: begin
        if (!b.task_runnable) r.status = mlrq_pkg::ST_NOT_RUNNABLE;
        else if (on_queue[b.task_id]) r.status = mlrq_pkg::ST_ALREADY_QUEUED;
        else begin
          q = level_of(b.task_priority);
          if (depth_of[q] != 0) link_of[tail_of[q]] = b.task_id;
          else head_of[q] = b.task_id;
          tail_of[q] = b.task_id;
          depth_of[q]++;
          on_queue[b.task_id] = 1'b1;
        end
      end
      mlrq_pkg::CMD_DEQUEUE: begin
        r.status = mlrq_pkg::ST_ALL_EMPTY;
        for (int i = 0; i < NQ; i++) begin
          if (depth_of[i] != 0) begin
            r.found_task = head_of[i];
            depth_of[i]--;
            if (depth_of[i] != 0) head_of[i] = link_of[r.found_task];
            on_queue[r.found_task] = 1'b0;
            r.status = mlrq_pkg::ST_OK;
            break;
          end
        end
      end
      mlrq_pkg::CMD_TICK: begin
        r.new_slice = b.current_slice;
        if (!sched_on) r.status = mlrq_pkg::ST_NOT_RUNNING;
        else begin
          if (b.current_is_idle) r.preempt_now = busy_above(NQ);
          else begin
            r.preempt_now = busy_above(level_of(b.task_priority));
            // slice only burns when nothing better is waiting
            if (!r.preempt_now && r.new_slice != 0) r.new_slice--;
          end
          r.slice_expired = (r.new_slice == 0);
        end
      end
      default: begin
        if (b.queue_index >= NQ) r.status = mlrq_pkg::ST_BAD_INDEX;
        else r.queue_length = 7'((depth_of[b.queue_index] > 127) ? 127
                                                                 : depth_of[b.queue_index]);
      end
    endcase
    return r;
  endfunction

  function automatic mlrq_pkg::in_beat_t cmd_beat(mlrq_pkg::cmd_t c, logic [5:0] id,
                                                  logic [7:0] prio, logic run, logic idle,
                                                  logic [15:0] slice, logic [3:0] qi);
    mlrq_pkg::in_beat_t b;
    b.command = c;
    b.task_id = id;
    b.task_priority = prio;
    b.task_runnable = run;
    b.current_is_idle = idle;
    b.current_slice = slice;
    b.queue_index = qi;
    return b;
  endfunction

  function automatic mlrq_pkg::out_beat_t res(mlrq_pkg::status_t st, logic [5:0] found,
                                              logic need, logic [15:0] slice, logic exp,
                                              logic [6:0] len);
    mlrq_pkg::out_beat_t r;
    r.status = st;
    r.found_task = found;
    r.preempt_now = need;
    r.new_slice = slice;
    r.slice_expired = exp;
    r.queue_length = len;
    return r;
  endfunction

  function automatic void add(mlrq_pkg::in_beat_t b, bit typed, mlrq_pkg::out_beat_t r);
    rows.push_back('{ROW_BEAT, 1'b0, b, typed, r});
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch @%0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Result checker: oldest expectation first
  always @(posedge clk) begin
    mlrq_pkg::out_beat_t w;
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (pending_results.size() == 0) report("unexpected result beat", 1, 0);
      else begin
        w = pending_results.pop_front();
        if (out_data.status != w.status) report("status", out_data.status, w.status);
        if (out_data.found_task != w.found_task)
          report("found_task", out_data.found_task, w.found_task);
        if (out_data.preempt_now != w.preempt_now)
          report("preempt_now", out_data.preempt_now, w.preempt_now);
        if (out_data.new_slice != w.new_slice)
          report("new_slice", out_data.new_slice, w.new_slice);
        if (out_data.slice_expired != w.slice_expired)
          report("slice_expired", out_data.slice_expired, w.slice_expired);
        if (out_data.queue_length != w.queue_length)
          report("queue_length", out_data.queue_length, w.queue_length);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk)
    out_stall <= !rst && ($urandom_range(99) < recv_stall);

  // Watchdog: any beat on any channel resets the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIM) begin
        $display("watchdog expired, %0d results still due", pending_results.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send(mlrq_pkg::in_beat_t b, bit typed, mlrq_pkg::out_beat_t r);
    mlrq_pkg::out_beat_t m;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    m = schedule_model(b);
    pending_results.push_back(typed ? r : m);
    beats_in++;
    cmd_seen[b.command]++;
  endtask

  // Register write: only once the block has gone quiet
  task automatic write_running(logic v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sched_on = v;
  endtask

  function automatic mlrq_pkg::in_beat_t random_beat();
    mlrq_pkg::in_beat_t b;
    int pick, tries;
    b = mlrq_pkg::in_beat_t'($bits(mlrq_pkg::in_beat_t)'({$urandom, $urandom}));
    pick = $urandom_range(99);
    if (pick < 42) begin
      b.command = mlrq_pkg::CMD_ENQUEUE;
      b.task_runnable = ($urandom_range(9) != 0);
      // mostly fresh tasks, so the queues actually grow
      tries = ($urandom_range(3) != 0) ? 8 : 0;
      while (tries > 0 && on_queue[b.task_id]) begin
        b.task_id = $urandom_range(NT - 1);
        tries--;
      end
    end else if (pick < 72) b.command = mlrq_pkg::CMD_DEQUEUE;
    else if (pick < 90) begin
      b.command = mlrq_pkg::CMD_TICK;
      b.current_is_idle = ($urandom_range(4) == 0);
      case ($urandom_range(4))
        0: b.current_slice = 16'd0;
        1: b.current_slice = 16'd1;
        2: b.current_slice = 16'hFFFF;
        default: ;
      endcase
    end else b.command = mlrq_pkg::CMD_LENGTH;
    return b;
  endfunction

  initial begin
    for (int i = 0; i < NQ; i++) depth_of[i] = 0;
    for (int i = 0; i < NT; i++) on_queue[i] = 1'b0;
    sched_on = 1'b0;

    // Reset state, not running
    add(cmd_beat(mlrq_pkg::CMD_TICK, 0, 0, 0, 0, 16'd1234, 0), 1,
        res(mlrq_pkg::ST_NOT_RUNNING, 0, 0, 16'd1234, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 1,
        res(mlrq_pkg::ST_ALL_EMPTY, 0, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_LENGTH, 0, 0, 0, 0, 0, 4'd15), 1,
        res(mlrq_pkg::ST_BAD_INDEX, 0, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_LENGTH, 0, 0, 0, 0, 0, 4'd8), 1,
        res(mlrq_pkg::ST_BAD_INDEX, 0, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_LENGTH, 0, 0, 0, 0, 0, 4'd0), 1,
        res(mlrq_pkg::ST_OK, 0, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_ENQUEUE, 6'd63, 8'd255, 0, 0, 0, 0), 1,
        res(mlrq_pkg::ST_NOT_RUNNABLE, 0, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_ENQUEUE, 6'd63, 8'd255, 1, 0, 0, 0), 1,
        res(mlrq_pkg::ST_OK, 0, 0, 0, 0, 0));
    // queued and not runnable: not runnable wins
    add(cmd_beat(mlrq_pkg::CMD_ENQUEUE, 6'd63, 8'd0, 0, 0, 0, 0), 1,
        res(mlrq_pkg::ST_NOT_RUNNABLE, 0, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_ENQUEUE, 6'd63, 8'd0, 1, 0, 0, 0), 1,
        res(mlrq_pkg::ST_ALREADY_QUEUED, 0, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_ENQUEUE, 6'd0, 8'd0, 1, 0, 0, 0), 1,
        res(mlrq_pkg::ST_OK, 0, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_ENQUEUE, 6'd5, 8'd31, 1, 0, 0, 0), 0, '0);
    add(cmd_beat(mlrq_pkg::CMD_LENGTH, 0, 0, 0, 0, 0, 4'd7), 1,
        res(mlrq_pkg::ST_OK, 0, 0, 0, 0, 7'd1));
    add(cmd_beat(mlrq_pkg::CMD_LENGTH, 0, 0, 0, 0, 0, 4'd0), 1,
        res(mlrq_pkg::ST_OK, 0, 0, 0, 0, 7'd2));
    rows.push_back('{ROW_CFG, 1'b1, '0, 0, '0});
    // Running: preemption and slice edges
    add(cmd_beat(mlrq_pkg::CMD_TICK, 0, 0, 0, 1, 16'd0, 0), 1,
        res(mlrq_pkg::ST_OK, 0, 1, 16'd0, 1, 0));
    add(cmd_beat(mlrq_pkg::CMD_TICK, 0, 8'd0, 0, 0, 16'hFFFF, 0), 1,
        res(mlrq_pkg::ST_OK, 0, 0, 16'hFFFE, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_TICK, 0, 8'd255, 0, 0, 16'd5, 0), 0, '0);
    add(cmd_beat(mlrq_pkg::CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 1,
        res(mlrq_pkg::ST_OK, 6'd0, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 1,
        res(mlrq_pkg::ST_OK, 6'd5, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 1,
        res(mlrq_pkg::ST_OK, 6'd63, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 1,
        res(mlrq_pkg::ST_ALL_EMPTY, 0, 0, 0, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_TICK, 0, 0, 0, 1, 16'd7, 0), 1,
        res(mlrq_pkg::ST_OK, 0, 0, 16'd7, 0, 0));
    add(cmd_beat(mlrq_pkg::CMD_TICK, 0, 8'd100, 0, 0, 16'd1, 0), 1,
        res(mlrq_pkg::ST_OK, 0, 0, 16'd0, 1, 0));
    add(cmd_beat(mlrq_pkg::CMD_TICK, 0, 8'd100, 0, 0, 16'd0, 0), 0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_running(rows[i].cfg_val);
      else send(rows[i].beat, rows[i].typed, rows[i].result);
    end

    // Random phases: idle rates rotate, the register toggles between them
    for (int ph = 0; ph < 4; ph++) begin
      write_running(ph[0]);
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 85; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 85; end
        default: begin send_idle = 9; recv_stall = 9; end
      endcase
      for (int n = 0; n < PHASE_N; n++) send(random_beat(), 0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d command beats sent, %0d results checked, %0d mismatches",
             beats_in, beats_out, errors);
    $display("enqueue %0d, dequeue %0d, tick %0d, length %0d; register run both ways",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
